>>> hdl/ypid_pkg.sv
// Package for the yaw PID thruster mixer: widths, gain record, fixed-point
// constants and the reciprocal used to scale the PID sum down to percent.
// No dependencies.
`timescale 1ns / 1ps

package ypid_pkg;

  // Control loop rate in ticks per second
  localparam int RATE_HZ = 50;

  // Field widths
  localparam int YAW_W   = 15;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 16;
  localparam int DERR_W  = ERR_W + 1;
  localparam int ACC_W   = 40;
  localparam int DRIVE_W = 8;

  // Accumulator split for the integral product
  localparam int ACC_LO_W = 20;
  localparam int ACC_HI_W = ACC_W - ACC_LO_W;

  // Gains carry 8 fraction bits, yaw 6, so the product has 14
  localparam int FRAC_SHIFT = 14;
  localparam int DRIVE_LIM  = 100;

  // Width of the full PID sum before scaling
  localparam int SUM_W = 60;

  // Scaled magnitude below the clamp point fits M2_W bits
  localparam int LIM_M2    = DRIVE_LIM * RATE_HZ;
  localparam int M2_W      = $clog2(LIM_M2);
  localparam int RECIP_SH  = M2_W;
  localparam int RECIP_K   = (1 << RECIP_SH) / RATE_HZ;
  localparam int RATE_SQ   = RATE_HZ * RATE_HZ;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } gains_t;

endpackage

>>> hdl/ypid_if.sv
// Valid/ready channel interfaces for the yaw PID thruster mixer: one for
// yaw ticks into the block, one for thruster drives out of it.
// Depends on ypid_pkg.
`timescale 1ns / 1ps

interface ypid_in_if
  import ypid_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [YAW_W-1:0] target_yaw;
  logic signed [YAW_W-1:0] measured_yaw;

  modport source (output valid, output target_yaw, output measured_yaw, input ready);
  modport sink   (input valid, input target_yaw, input measured_yaw, output ready);
endinterface

interface ypid_out_if
  import ypid_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] right_drive;
  logic signed [DRIVE_W-1:0] left_drive;

  modport source (output valid, output right_drive, output left_drive, input ready);
  modport sink   (input valid, input right_drive, input left_drive, output ready);
endinterface

>>> hdl/ypid_cfg_regs.sv
// APB-style gain register file for the yaw PID thruster mixer.
// Depends on ypid_pkg for the gain record.
`timescale 1ns / 1ps

module ypid_cfg_regs
  import ypid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  output gains_t      gains_o
);

  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INT   = 2'd1,
    REG_DERIV = 2'd2
  } reg_idx_e;

  gains_t     gains_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign reg_idx  = paddr_i[3:2];
  assign gains_o  = gains_q;

  // Write the addressed gain; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop  <= GAIN_W'(256);
      gains_q.integ <= '0;
      gains_q.deriv <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PROP:  gains_q.prop  <= pwdata_i[GAIN_W-1:0];
        REG_INT:   gains_q.integ <= pwdata_i[GAIN_W-1:0];
        REG_DERIV: gains_q.deriv <= pwdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_PROP:  prdata_o = 32'(gains_q.prop);
      REG_INT:   prdata_o = 32'(gains_q.integ);
      REG_DERIV: prdata_o = 32'(gains_q.deriv);
      default:   prdata_o = '0;
    endcase
  end

endmodule

>>> hdl/yaw_pid_thruster_mix.sv
// Yaw PID controller with differential thruster mix: top level.
// Depends on ypid_pkg, ypid_in_if, ypid_out_if and ypid_cfg_regs.
//
// Usage:
//   in_i carries one control tick per transaction (target and measured yaw,
//   signed, 6 fraction bits). out_o returns one transaction per tick with
//   the right and left thruster drives in percent, clamped to +/-100.
//   The APB port sets the proportional, integral and derivative gains
//   (signed Q8.8) at byte addresses 0, 4 and 8; write only while idle.
// Timing:
//   A tick accepted on in_i passes, in order, an error/accumulator stage,
//   two product stages, a sum and magnitude stage, a reciprocal-multiply
//   stage and the output register before its result shows on out_o.
//   One tick is taken per cycle while in_i.ready is high; the accumulator
//   and previous error update in the first stage, so ticks run back to back.
// Reset and stall:
//   Reset clears the accumulator, the previous error and all stage valids,
//   and loads the gains 1.0, 0, 0. A stalled receiver holds the output
//   register; stages behind it fill until the pipeline is full, then
//   in_i.ready drops.
`timescale 1ns / 1ps

module yaw_pid_thruster_mix
  import ypid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ypid_in_if.sink     in_i,
  ypid_out_if.source  out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam logic signed [SUM_W-1:0]  RATE_S    = SUM_W'(RATE_HZ);
  localparam logic signed [SUM_W-1:0]  RATE_SQ_S = SUM_W'(RATE_SQ);
  localparam logic signed [ACC_W-1:0]  ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  gains_t gains;

  ypid_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .gains_o   (gains)
  );

  // Stage valids and ready chain; index 6 is the output register
  logic [6:1] vld_q;
  logic [6:1] rdy;

  always_comb begin
    rdy[6] = !vld_q[6] || out_o.ready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready  = rdy[1];
  assign out_o.valid = vld_q[6];

  logic in_acc;
  assign in_acc = in_i.valid && rdy[1];

  // Advance valids where the next stage can take them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= in_i.valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---- Stage 1: error, saturating accumulator, error difference ----
  logic signed [ACC_W-1:0]  error_sum_q;
  logic signed [ERR_W-1:0]  last_error_q;
  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic signed [ACC_W:0]    acc_wide;
  logic signed [ACC_W-1:0]  acc_sat;

  always_comb begin
    err      = ERR_W'(in_i.target_yaw) - ERR_W'(in_i.measured_yaw);
    derr     = DERR_W'(err) - DERR_W'(last_error_q);
    acc_wide = (ACC_W+1)'(error_sum_q) + (ACC_W+1)'(err);
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      acc_sat = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_wide[ACC_W-1:0];
    end
  end

  // Update loop state on every accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (in_acc) begin
      error_sum_q  <= acc_sat;
      last_error_q <= err;
    end
  end

  logic signed [ERR_W-1:0]  s1_err_q;
  logic signed [DERR_W-1:0] s1_derr_q;
  logic signed [ACC_W-1:0]  s1_acc_q;

  // ---- Stage 2: gain products, integral split in two halves ----
  logic signed [2*GAIN_W-1:0]          p_prod;
  logic signed [GAIN_W+DERR_W-1:0]     d_prod;
  logic signed [GAIN_W+ACC_HI_W-1:0]   ih_prod;
  logic signed [GAIN_W+ACC_LO_W:0]     il_prod;

  always_comb begin
    p_prod  = gains.prop * s1_err_q;
    d_prod  = gains.deriv * s1_derr_q;
    ih_prod = gains.integ * $signed(s1_acc_q[ACC_W-1:ACC_LO_W]);
    il_prod = gains.integ * $signed({1'b0, s1_acc_q[ACC_LO_W-1:0]});
  end

  logic signed [2*GAIN_W-1:0]        s2_p_q;
  logic signed [GAIN_W+DERR_W-1:0]   s2_d_q;
  logic signed [GAIN_W+ACC_HI_W-1:0] s2_ih_q;
  logic signed [GAIN_W+ACC_LO_W:0]   s2_il_q;

  // ---- Stage 3: rate scaling and integral recombine ----
  logic signed [SUM_W-1:0] p_term;
  logic signed [SUM_W-1:0] d_term;
  logic signed [SUM_W-1:0] i_term;

  always_comb begin
    p_term = SUM_W'(s2_p_q) * RATE_S;
    d_term = SUM_W'(s2_d_q) * RATE_SQ_S;
    i_term = (SUM_W'(s2_ih_q) <<< ACC_LO_W) + SUM_W'(s2_il_q);
  end

  logic signed [SUM_W-1:0] s3_p_q;
  logic signed [SUM_W-1:0] s3_d_q;
  logic signed [SUM_W-1:0] s3_i_q;

  // ---- Stage 4: sum, magnitude, drop fraction, detect clamp ----
  logic signed [SUM_W-1:0] pid_sum;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        mag_int;
  logic                    sum_ovf;

  always_comb begin
    pid_sum = s3_p_q + s3_d_q + s3_i_q;
    sum_neg = pid_sum[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-pid_sum) : SUM_W'(pid_sum);
    mag_int = sum_mag >> FRAC_SHIFT;
    sum_ovf = mag_int >= SUM_W'(LIM_M2);
  end

  logic            s4_neg_q;
  logic            s4_ovf_q;
  logic [M2_W-1:0] s4_m2_q;

  // ---- Stage 5: estimate quotient by the rate through a reciprocal ----
  logic [2*M2_W:0] recip_prod;
  logic [M2_W-1:0] quo_est;

  always_comb begin
    recip_prod = (2*M2_W+1)'(s4_m2_q) * (2*M2_W+1)'(RECIP_K);
    quo_est    = recip_prod[RECIP_SH+M2_W-1:RECIP_SH];
  end

  logic            s5_neg_q;
  logic            s5_ovf_q;
  logic [M2_W-1:0] s5_m2_q;
  logic [M2_W-1:0] s5_quo_q;

  // ---- Stage 6: correct estimate, clamp, apply sign and mix ----
  logic [M2_W-1:0]           quo_back;
  logic [M2_W-1:0]           quo_rem;
  logic [M2_W-1:0]           quo_fix;
  logic signed [DRIVE_W-1:0] drive_mag;
  logic signed [DRIVE_W-1:0] right_d;
  logic signed [DRIVE_W-1:0] left_d;

  always_comb begin
    quo_back = M2_W'((2*M2_W)'(s5_quo_q) * (2*M2_W)'(RATE_HZ));
    quo_rem  = s5_m2_q - quo_back;
    quo_fix  = (quo_rem >= M2_W'(RATE_HZ)) ? s5_quo_q + M2_W'(1) : s5_quo_q;
    drive_mag = s5_ovf_q ? DRIVE_W'(DRIVE_LIM) : DRIVE_W'(quo_fix);
    right_d   = s5_neg_q ? -drive_mag : drive_mag;
    left_d    = -right_d;
  end

  logic signed [DRIVE_W-1:0] right_q;
  logic signed [DRIVE_W-1:0] left_q;

  assign out_o.right_drive = right_q;
  assign out_o.left_drive  = left_q;

  // Payload registers load with their stage
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_err_q  <= err;
      s1_derr_q <= derr;
      s1_acc_q  <= acc_sat;
    end
    if (rdy[2]) begin
      s2_p_q  <= p_prod;
      s2_d_q  <= d_prod;
      s2_ih_q <= ih_prod;
      s2_il_q <= il_prod;
    end
    if (rdy[3]) begin
      s3_p_q <= p_term;
      s3_d_q <= d_term;
      s3_i_q <= i_term;
    end
    if (rdy[4]) begin
      s4_neg_q <= sum_neg;
      s4_ovf_q <= sum_ovf;
      s4_m2_q  <= mag_int[M2_W-1:0];
    end
    if (rdy[5]) begin
      s5_neg_q <= s4_neg_q;
      s5_ovf_q <= s4_ovf_q;
      s5_m2_q  <= s4_m2_q;
      s5_quo_q <= quo_est;
    end
    if (rdy[6]) begin
      right_q <= right_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> bench/ypid_tb_pkg.sv
// Bench-side constants for the yaw PID thruster mixer: gain register indexes
// and their reset values, shared by the stimulus and the checker.
// No dependencies.
`timescale 1ns / 1ps

package ypid_tb_pkg;

  // Register index, taken from byte address bits [3:2]
  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2,
    REG_SPARE = 2'd3
  } gain_reg_e;

  // Gains after reset: 1.0, 0, 0 in Q8.8
  localparam logic signed [15:0] PROP_GAIN_RESET  = 16'sd256;
  localparam logic signed [15:0] INTEG_GAIN_RESET = 16'sd0;
  localparam logic signed [15:0] DERIV_GAIN_RESET = 16'sd0;

endpackage

>>> bench/ypid_mix_checker.sv
// Passive checker for the yaw PID thruster mixer: tracks gain writes on the
// APB port, predicts both thruster drives per tick and compares in order.
// Depends on ypid_pkg, ypid_tb_pkg, ypid_in_if and ypid_out_if.
`timescale 1ns / 1ps

module ypid_mix_checker
  import ypid_pkg::*;
  import ypid_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ypid_in_if          in_ch,
  ypid_out_if         out_ch,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          clamped_o
);

  localparam longint ACC_TOP = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_BOT = -ACC_TOP - 1;

  typedef struct packed {
    int                        tick;
    logic signed [DRIVE_W-1:0] right;
    logic signed [DRIVE_W-1:0] left;
  } drive_t;

  drive_t                  drive_q[$];
  gains_t                  gains;
  logic signed [ACC_W-1:0] err_acc;
  logic signed [ERR_W-1:0] prev_err;
  int                      ticks_in;
  int                      mismatches;
  int                      results;
  int                      clamped;

  // Saturate a scaled PID output to the drive range
  function automatic logic signed [DRIVE_W-1:0] clamp_pct(input longint v);
    longint c;
    c = v;
    if (c > DRIVE_LIM) c = DRIVE_LIM;
    else if (c < -DRIVE_LIM) c = -DRIVE_LIM;
    return c[DRIVE_W-1:0];
  endfunction

  // Advance the loop state by one tick and return the drives it yields
  function automatic drive_t step_yaw_loop(input logic signed [YAW_W-1:0] tgt,
                                           input logic signed [YAW_W-1:0] meas);
    longint err;
    longint acc;
    longint pid_sum;
    longint quo;
    drive_t d;
    err = longint'(tgt) - longint'(meas);
    acc = longint'(err_acc) + err;
    if (acc > ACC_TOP) acc = ACC_TOP;
    else if (acc < ACC_BOT) acc = ACC_BOT;
    // Exact sum with the integral and derivative scaling folded in
    pid_sum = longint'($signed(gains.prop)) * err * RATE_HZ
            + longint'($signed(gains.integ)) * acc
            + longint'($signed(gains.deriv)) * (err - longint'(prev_err)) * RATE_SQ;
    quo = pid_sum / (longint'(RATE_HZ) <<< FRAC_SHIFT);
    err_acc  = acc[ACC_W-1:0];
    prev_err = err[ERR_W-1:0];
    d.tick  = ticks_in;
    d.right = clamp_pct(quo);
    d.left  = clamp_pct(-quo);
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] drive check: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_t want;
    if (!rst_ni) begin
      gains.prop  = PROP_GAIN_RESET;
      gains.integ = INTEG_GAIN_RESET;
      gains.deriv = DERIV_GAIN_RESET;
      err_acc     = '0;
      prev_err    = '0;
      drive_q.delete();
      ticks_in    = 0;
      mismatches  = 0;
      results     = 0;
      clamped     = 0;
    end else begin
      // Track gain writes; the spare index is dropped
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (gain_reg_e'(paddr_i[3:2]))
          REG_PROP:  gains.prop  = pwdata_i[GAIN_W-1:0];
          REG_INTEG: gains.integ = pwdata_i[GAIN_W-1:0];
          REG_DERIV: gains.deriv = pwdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end

      // Predict each accepted tick
      if (in_ch.valid && in_ch.ready) begin
        drive_q.push_back(step_yaw_loop(in_ch.target_yaw, in_ch.measured_yaw));
        ticks_in++;
      end

      // Compare each delivered drive with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("unexpected drive right %0d left %0d",
                                    out_ch.right_drive, out_ch.left_drive));
        end else begin
          want = drive_q.pop_front();
          results++;
          if (want.right == DRIVE_LIM || want.left == DRIVE_LIM) clamped++;
          if (out_ch.right_drive !== want.right)
            report_mismatch($sformatf("tick %0d right_drive %0d, expected %0d",
                                      want.tick, out_ch.right_drive, want.right));
          if (out_ch.left_drive !== want.left)
            report_mismatch($sformatf("tick %0d left_drive %0d, expected %0d",
                                      want.tick, out_ch.left_drive, want.left));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= drive_q.size();
    results_o    <= results;
    clamped_o    <= clamped;
  end

endmodule

>>> bench/tb_yaw_pid_thruster_mix.sv
// Testbench top for the yaw PID thruster mixer: drives ticks and gain writes
// with random idle bursts, and gives the verdict from the checker's count.
// Depends on ypid_pkg, ypid_tb_pkg, the channel interfaces and ypid_mix_checker.
`timescale 1ns / 1ps

module tb_yaw_pid_thruster_mix;
  import ypid_pkg::*;
  import ypid_tb_pkg::*;

  localparam int N_PHASES    = 8;
  localparam int PHASE_TICKS = 156;
  localparam int YAW_MAX     = 11519;
  localparam int YAW_MIN     = -11520;

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [3:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  int  fail_count;
  int  pending;
  int  results;
  int  clamped;
  int  ticks_sent;
  int  settings_used;
  bit  quiet;

  ypid_in_if  yaw_in ();
  ypid_out_if drive_out ();

  yaw_pid_thruster_mix uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (yaw_in),
    .out_o     (drive_out),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  ypid_mix_checker drive_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (yaw_in),
    .out_ch       (drive_out),
    .psel_i       (psel_i),
    .penable_i    (penable_i),
    .pwrite_i     (pwrite_i),
    .pready_i     (pready_o),
    .paddr_i      (paddr_i),
    .pwdata_i     (pwdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .clamped_o    (clamped)
  );

  // Clock, 8 ns period
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Timed out with %0d drives outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall in random bursts, never in the quiet tail
  initial begin
    drive_out.ready = 1'b1;
    @(posedge clk_i);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        drive_out.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        drive_out.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [YAW_W-1:0] clip_yaw(input int v);
    int c;
    c = v;
    if (c > YAW_MAX) c = YAW_MAX;
    else if (c < YAW_MIN) c = YAW_MIN;
    return c[YAW_W-1:0];
  endfunction

  // Random gain: mostly modest, sometimes any 16-bit pattern
  function automatic logic signed [GAIN_W-1:0] pick_gain(input int span);
    if ($urandom_range(0, 3) == 0) return GAIN_W'($urandom);
    return GAIN_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Send one tick, with an optional idle burst ahead of it
  task automatic send_tick(input logic signed [YAW_W-1:0] tgt,
                           input logic signed [YAW_W-1:0] meas);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      yaw_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    yaw_in.valid        <= 1'b1;
    yaw_in.target_yaw   <= tgt;
    yaw_in.measured_yaw <= meas;
    do @(posedge clk_i); while (!yaw_in.ready);
    ticks_sent++;
  endtask

  // Hold off until every drive is back and the pipeline has emptied
  task automatic wait_drained();
    yaw_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input gain_reg_e idx, input logic [31:0] data);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load all three gains; junk goes in the upper bits and the spare slot
  task automatic load_gains(input logic signed [GAIN_W-1:0] kp,
                            input logic signed [GAIN_W-1:0] ki,
                            input logic signed [GAIN_W-1:0] kd);
    write_reg(REG_PROP,  {16'($urandom), kp});
    write_reg(REG_INTEG, {16'($urandom), ki});
    write_reg(REG_DERIV, {16'($urandom), kd});
    write_reg(REG_SPARE, $urandom);
    settings_used++;
  endtask

  initial begin
    int tgt_pos;
    int meas_pos;
    int mode;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;

    rst_ni              = 1'b0;
    psel_i              = 1'b0;
    penable_i           = 1'b0;
    pwrite_i            = 1'b0;
    paddr_i             = '0;
    pwdata_i            = '0;
    yaw_in.valid        = 1'b0;
    yaw_in.target_yaw   = '0;
    yaw_in.measured_yaw = '0;
    quiet               = 1'b0;
    ticks_sent          = 0;
    settings_used       = 1;
    tgt_pos             = 0;
    meas_pos            = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains (pure proportional, 1.0): yaw range extremes, rounding, clamp edge
    send_tick(15'sd0, 15'sd0);
    send_tick(clip_yaw(YAW_MAX), clip_yaw(YAW_MIN));
    send_tick(clip_yaw(YAW_MIN), clip_yaw(YAW_MAX));
    send_tick(clip_yaw(YAW_MAX), clip_yaw(YAW_MAX));
    send_tick(clip_yaw(YAW_MIN), clip_yaw(YAW_MIN));
    send_tick(15'sd64, 15'sd0);
    send_tick(15'sd6399, 15'sd0);
    send_tick(15'sd6400, 15'sd0);
    send_tick(15'sd6464, 15'sd0);
    send_tick(-15'sd6399, 15'sd0);
    send_tick(-15'sd1, 15'sd0);
    // Patterns outside the stated yaw range
    send_tick(15'sh3fff, 15'sh4000);
    send_tick(15'sh4000, 15'sh3fff);

    // Extreme gains on a few directed ticks
    wait_drained();
    load_gains(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_tick(15'sd1, 15'sd0);
    send_tick(15'sd0, 15'sd1);
    send_tick(15'sh3fff, 15'sh4000);
    send_tick(15'sh4000, 15'sh3fff);
    send_tick(15'sd0, 15'sd0);

    // Random phases, each under its own gain setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin kp = 16'sh8000; ki = 16'sh7fff; kd = 16'sh8000; end
        1: begin kp = 16'sd0;    ki = 16'sd0;    kd = 16'sd0;    end
        2: begin kp = 16'sh7fff; ki = 16'sh7fff; kd = 16'sh7fff; end
        default: begin
          kp = pick_gain(1024);
          ki = pick_gain(1024);
          kd = pick_gain(32);
        end
      endcase
      load_gains(kp, ki, kd);
      if (ph == N_PHASES - 1) quiet = 1'b1;

      for (int k = 0; k < PHASE_TICKS; k++) begin
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
          // Tracking: the heading chases a target that jumps now and then
          if ($urandom_range(0, 19) == 0) tgt_pos = $urandom_range(0, 23039) + YAW_MIN;
          meas_pos = meas_pos + (tgt_pos - meas_pos) / 8 + int'($urandom_range(0, 64)) - 32;
          meas_pos = int'(clip_yaw(meas_pos));
          send_tick(clip_yaw(tgt_pos), clip_yaw(meas_pos));
        end else if (mode < 85) begin
          send_tick(clip_yaw(int'($urandom_range(0, 23039)) + YAW_MIN),
                    clip_yaw(int'($urandom_range(0, 23039)) + YAW_MIN));
        end else begin
          send_tick(YAW_W'($urandom), YAW_W'($urandom));
        end
        if (ph == 3 && k == PHASE_TICKS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Sent %0d ticks under %0d gain settings, idle bursts on both sides",
             ticks_sent, settings_used);
    $display("Checked %0d drive pairs, %0d of them at the clamp", results, clamped);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ypid_pkg.sv
hdl/ypid_if.sv
hdl/ypid_cfg_regs.sv
hdl/yaw_pid_thruster_mix.sv
bench/ypid_tb_pkg.sv
bench/ypid_mix_checker.sv
bench/tb_yaw_pid_thruster_mix.sv
